>>> hdl/volume_curve_gain_stage_core_assert.svh
// ---------------------------------------------------------------------------
// volume curve gain stage assertion macros
// shared concurrent assertion helpers, clocked on clk, off during reset
// ---------------------------------------------------------------------------
`ifndef VOLUME_CURVE_GAIN_STAGE_CORE_ASSERT_SVH
`define VOLUME_CURVE_GAIN_STAGE_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define VCGS_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define VCGS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/vcgs_pkg.sv
// ---------------------------------------------------------------------------
// volume curve gain stage package
// request types, register indexes, curve codes and the sine table function
// ---------------------------------------------------------------------------
package vcgs_pkg;

  localparam int SINE_TABLE_BITS_DEF = 8;
  localparam int LEVEL_FRAC_BITS_DEF = 15;
  localparam int CFG_INDEX_W         = 3;
  localparam int CFG_DATA_W          = 32;
  localparam logic [16:0] SINE_ONE   = 17'd32768;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CURVE_START       = 3'd0,
    REG_CURVE_END         = 3'd1,
    REG_START_LEVEL       = 3'd2,
    REG_END_LEVEL         = 3'd3,
    REG_CURVE_SHAPE       = 3'd4,
    REG_BASE_LEVEL        = 3'd5,
    REG_INSTRUMENT_VOLUME = 3'd6,
    REG_MASTER_VOLUME     = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    SHAPE_LINEAR  = 3'd0,
    SHAPE_INSTANT = 3'd1,
    SHAPE_SQUARE  = 3'd2,
    SHAPE_SQRT    = 3'd3,
    SHAPE_SINE    = 3'd4
  } shape_t;

  typedef enum logic [1:0] {
    MODE_BASE  = 2'd0,
    MODE_END   = 2'd1,
    MODE_CURVE = 2'd2
  } mode_t;

  typedef struct packed {
    logic [31:0]        frame_position;
    logic signed [15:0] left_in;
    logic signed [15:0] right_in;
  } in_req_t;

  typedef struct packed {
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
    logic [15:0]        gain_level;
    logic               clipped;
  } out_req_t;

  // quarter sine entry k of a 2^tb table, Q1.15
  function automatic logic [16:0] sine_entry(input int k, input int tb);
    longint unsigned x, x2, p, s, v;
    x  = 64'(k) << (30 - tb);
    x2 = (x * x) >> 30;
    p  = 64'd172272;
    p  = 64'd5026995 - ((x2 * p) >> 30);
    p  = 64'd85569306 - ((x2 * p) >> 30);
    p  = 64'd693598668 - ((x2 * p) >> 30);
    p  = 64'd1686629713 - ((x2 * p) >> 30);
    s  = (x * p) >> 30;
    v  = (s + 64'd16384) >> 15;
    if (v > 64'd32768) v = 64'd32768;
    return 17'(v);
  endfunction

endpackage

>>> hdl/volume_curve_gain_stage_core.sv
// ---------------------------------------------------------------------------
// volume curve gain stage core
// curve level from one segment, then stereo gain with saturation
// ---------------------------------------------------------------------------
// One stereo frame enters per clock while the output is not stalled. The
// depth is set by the restoring divider for the curve fraction and the square
// root unit, one quotient or root bit per stage, followed by the level
// multiply and the gain multiply chain. A stall on the output holds the whole
// pipeline; configuration must be written only while the pipeline is empty.
module volume_curve_gain_stage_core #(
  parameter int SINE_TABLE_BITS = vcgs_pkg::SINE_TABLE_BITS_DEF,
  parameter int LEVEL_FRAC_BITS = vcgs_pkg::LEVEL_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  vcgs_pkg::in_req_t                   in_payload,
  output logic                                out_valid,
  input  logic                                out_stall,
  output vcgs_pkg::out_req_t                  out_payload,
  input  logic                                cfg_we,
  input  logic [vcgs_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [vcgs_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int F      = LEVEL_FRAC_BITS;
  localparam int TB     = SINE_TABLE_BITS;
  localparam int SINE_N = 1 << TB;

  typedef struct packed {
    vcgs_pkg::mode_t    mode;
    logic signed [15:0] left;
    logic signed [15:0] right;
  } side_t;

  // configuration
  logic [31:0] curve_start_r, curve_end_r;
  logic [15:0] start_level_r, end_level_r, base_level_r, inst_vol_r, master_vol_r;
  logic [2:0]  curve_shape_r;
  logic [31:0] range_r;
  logic [16:0] iv_sq_r;
  logic [15:0] lv_diff_r;
  logic        lv_up_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      curve_start_r <= '0;
      curve_end_r   <= '0;
      start_level_r <= '0;
      end_level_r   <= 16'd32768;
      curve_shape_r <= vcgs_pkg::SHAPE_LINEAR;
      base_level_r  <= 16'd32768;
      inst_vol_r    <= 16'd32768;
      master_vol_r  <= 16'd32768;
    end else if (cfg_we) begin
      unique case (vcgs_pkg::reg_idx_t'(cfg_index))
        vcgs_pkg::REG_CURVE_START:       curve_start_r <= cfg_wdata;
        vcgs_pkg::REG_CURVE_END:         curve_end_r   <= cfg_wdata;
        vcgs_pkg::REG_START_LEVEL:       start_level_r <= cfg_wdata[15:0];
        vcgs_pkg::REG_END_LEVEL:         end_level_r   <= cfg_wdata[15:0];
        vcgs_pkg::REG_CURVE_SHAPE:       curve_shape_r <= cfg_wdata[2:0];
        vcgs_pkg::REG_BASE_LEVEL:        base_level_r  <= cfg_wdata[15:0];
        vcgs_pkg::REG_INSTRUMENT_VOLUME: inst_vol_r    <= cfg_wdata[15:0];
        vcgs_pkg::REG_MASTER_VOLUME:     master_vol_r  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // values derived from configuration
  always_ff @(posedge clk) begin
    range_r   <= curve_end_r - curve_start_r;
    iv_sq_r   <= 17'((34'(inst_vol_r) * 34'(inst_vol_r) + 34'd16384) >> 15);
    lv_up_r   <= end_level_r >= start_level_r;
    lv_diff_r <= (end_level_r >= start_level_r) ? end_level_r - start_level_r
                                                 : start_level_r - end_level_r;
  end

  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  logic in_fire;
  assign in_fire = in_valid && en;

  // sine table
  logic [16:0] sine_tab [SINE_N+1];
  for (genvar k = 0; k <= SINE_N; k++) begin : g_tab
    assign sine_tab[k] = vcgs_pkg::sine_entry(k, TB);
  end

  // entry stage and divider
  logic        div_vld_r  [F+1];
  side_t       div_side_r [F+1];
  logic [31:0] div_rem_r  [F+1];
  logic [F-1:0] div_q_r   [F+1];

  side_t       a_side_nxt;
  logic [31:0] a_t_nxt;

  always_comb begin
    a_side_nxt.left  = in_payload.left_in;
    a_side_nxt.right = in_payload.right_in;
    if (curve_end_r <= curve_start_r || in_payload.frame_position < curve_start_r) begin
      a_side_nxt.mode = vcgs_pkg::MODE_BASE;
    end else if (curve_shape_r == vcgs_pkg::SHAPE_INSTANT) begin
      a_side_nxt.mode = vcgs_pkg::MODE_END;
    end else begin
      a_side_nxt.mode = vcgs_pkg::MODE_CURVE;
    end
    a_t_nxt = (in_payload.frame_position < curve_end_r)
            ? in_payload.frame_position - curve_start_r
            : curve_end_r - curve_start_r - 32'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_vld_r[0] <= 1'b0;
    end else if (en) begin
      div_vld_r[0] <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_side_r[0] <= a_side_nxt;
      div_rem_r[0]  <= a_t_nxt;
      div_q_r[0]    <= '0;
    end
  end

  for (genvar k = 0; k < F; k++) begin : g_div
    logic [32:0] r2;
    logic        ge;
    assign r2 = {div_rem_r[k], 1'b0};
    assign ge = r2 >= {1'b0, range_r};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        div_vld_r[k+1] <= 1'b0;
      end else if (en) begin
        div_vld_r[k+1] <= div_vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        div_side_r[k+1] <= div_side_r[k];
        div_rem_r[k+1]  <= ge ? 32'(r2 - {1'b0, range_r}) : r2[31:0];
        div_q_r[k+1]    <= {div_q_r[k][F-2:0], ge};
      end
    end
  end

  // shape stage: square, sine fetch, root start
  logic [F-1:0]  frac;
  logic [F+TB-1:0] spos;
  logic [TB:0]   sidx;
  assign frac = div_q_r[F];
  assign spos = {frac, {TB{1'b0}}};
  assign sidx = {1'b0, spos[F+TB-1:F]};

  logic [16:0] p0_lo_r, p0_sdiff_r;
  logic [F-1:0] p0_srem_r;

  logic        sq_vld_r  [F+1];
  side_t       sq_side_r [F+1];
  logic [F-1:0] sq_f_r   [F+1];
  logic [F-1:0] sq_g2_r  [F+1];
  logic [F:0]  sq_sin_r  [F+1];
  logic [F-1:0] sq_root_r[F+1];
  logic [F+1:0] sq_rem_r [F+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r[0] <= 1'b0;
    end else if (en) begin
      sq_vld_r[0] <= div_vld_r[F];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_side_r[0] <= div_side_r[F];
      sq_f_r[0]    <= frac;
      sq_g2_r[0]   <= F'((2*F)'(frac) * (2*F)'(frac) >> F);
      sq_sin_r[0]  <= '0;
      sq_root_r[0] <= '0;
      sq_rem_r[0]  <= '0;
      p0_lo_r      <= sine_tab[sidx];
      p0_sdiff_r   <= sine_tab[sidx + (TB+1)'(1)] - sine_tab[sidx];
      p0_srem_r    <= spos[F-1:0];
    end
  end

  // square root, one root bit per stage; sine interpolation in the first
  for (genvar k = 0; k < F; k++) begin : g_sqrt
    localparam int J = F - 1 - k;
    logic [2*F-1:0] vv;
    logic [F+1:0]   remc, trial;
    logic           ge;
    logic [F:0]     sin_nxt;
    assign vv    = {sq_f_r[k], {F{1'b0}}};
    assign remc  = {sq_rem_r[k][F-1:0], vv[2*J+1 -: 2]};
    assign trial = {sq_root_r[k], 2'b01};
    assign ge    = remc >= trial;

    if (k == 0) begin : g_sin
      logic [16+F:0] sprod;
      logic [16:0]   sval;
      logic [16+F:0] sscl;
      assign sprod   = (17+F)'(p0_sdiff_r) * (17+F)'(p0_srem_r);
      assign sval    = p0_lo_r + 17'(sprod >> F);
      assign sscl    = {sval, {F{1'b0}}} >> 15;
      assign sin_nxt = sscl[F:0];
    end else begin : g_hold
      assign sin_nxt = sq_sin_r[k];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[k+1] <= 1'b0;
      end else if (en) begin
        sq_vld_r[k+1] <= sq_vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_side_r[k+1] <= sq_side_r[k];
        sq_f_r[k+1]    <= sq_f_r[k];
        sq_g2_r[k+1]   <= sq_g2_r[k];
        sq_sin_r[k+1]  <= sin_nxt;
        sq_rem_r[k+1]  <= ge ? remc - trial : remc;
        sq_root_r[k+1] <= {sq_root_r[k][F-2:0], ge};
      end
    end
  end

  // level
  logic [F:0] g_sel;
  always_comb begin
    case (curve_shape_r)
      vcgs_pkg::SHAPE_SQUARE: g_sel = {1'b0, sq_g2_r[F]};
      vcgs_pkg::SHAPE_SQRT:   g_sel = {1'b0, sq_root_r[F]};
      vcgs_pkg::SHAPE_SINE:   g_sel = sq_sin_r[F];
      default:                g_sel = {1'b0, sq_f_r[F]};
    endcase
  end

  logic          l1_vld_r, l2_vld_r;
  side_t         l1_side_r, l2_side_r;
  logic [16+F:0] l1_prod_r;
  logic [15:0]   l2_lv_r, lv_nxt, lv_step;

  assign lv_step = 16'(l1_prod_r >> F);

  always_comb begin
    case (l1_side_r.mode)
      vcgs_pkg::MODE_BASE: lv_nxt = base_level_r;
      vcgs_pkg::MODE_END:  lv_nxt = end_level_r;
      default:             lv_nxt = lv_up_r ? start_level_r + lv_step
                                            : start_level_r - lv_step;
    endcase
  end

  // gain chain and scaling
  logic         g1_vld_r, g2_vld_r, g3_vld_r, m_vld_r;
  side_t        g1_side_r, g2_side_r, g3_side_r;
  logic [15:0]  g1_lv_r, g2_lv_r, g3_lv_r, m_lv_r;
  logic [16:0]  g1_b_r;
  logic [18:0]  g2_ab_r;
  logic [19:0]  g3_gain_r;
  logic [21:0]  m_mag_l_r, m_mag_r_r;
  logic         m_neg_l_r, m_neg_r_r;
  logic [16:0]  amag_l, amag_r;

  assign amag_l = g3_side_r.left[15]  ? 17'd0 - 17'(g3_side_r.left)  : 17'(g3_side_r.left);
  assign amag_r = g3_side_r.right[15] ? 17'd0 - 17'(g3_side_r.right) : 17'(g3_side_r.right);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l1_vld_r  <= 1'b0;
      l2_vld_r  <= 1'b0;
      g1_vld_r  <= 1'b0;
      g2_vld_r  <= 1'b0;
      g3_vld_r  <= 1'b0;
      m_vld_r   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      l1_vld_r  <= sq_vld_r[F];
      l2_vld_r  <= l1_vld_r;
      g1_vld_r  <= l2_vld_r;
      g2_vld_r  <= g1_vld_r;
      g3_vld_r  <= g2_vld_r;
      m_vld_r   <= g3_vld_r;
      out_valid <= m_vld_r;
    end
  end

  logic [21:0] sat_l_mag, sat_r_mag;
  logic        clip_l, clip_r;

  always_comb begin
    clip_l    = m_neg_l_r ? (m_mag_l_r > 22'd32768) : (m_mag_l_r > 22'd32767);
    clip_r    = m_neg_r_r ? (m_mag_r_r > 22'd32768) : (m_mag_r_r > 22'd32767);
    sat_l_mag = clip_l ? (m_neg_l_r ? 22'd32768 : 22'd32767) : m_mag_l_r;
    sat_r_mag = clip_r ? (m_neg_r_r ? 22'd32768 : 22'd32767) : m_mag_r_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l1_side_r <= sq_side_r[F];
      l1_prod_r <= (17+F)'(lv_diff_r) * (17+F)'(g_sel);
      l2_side_r <= l1_side_r;
      l2_lv_r   <= lv_nxt;
      g1_side_r <= l2_side_r;
      g1_lv_r   <= l2_lv_r;
      g1_b_r    <= 17'((32'(l2_lv_r) * 32'(l2_lv_r) + 32'd16384) >> 15);
      g2_side_r <= g1_side_r;
      g2_lv_r   <= g1_lv_r;
      g2_ab_r   <= 19'((34'(iv_sq_r) * 34'(g1_b_r) + 34'd16384) >> 15);
      g3_side_r <= g2_side_r;
      g3_lv_r   <= g2_lv_r;
      g3_gain_r <= 20'((35'(g2_ab_r) * 35'(master_vol_r) + 35'd16384) >> 15);
      m_lv_r    <= g3_lv_r;
      m_neg_l_r <= g3_side_r.left[15];
      m_neg_r_r <= g3_side_r.right[15];
      m_mag_l_r <= 22'((37'(amag_l) * 37'(g3_gain_r)) >> 15);
      m_mag_r_r <= 22'((37'(amag_r) * 37'(g3_gain_r)) >> 15);
      out_payload.left_out   <= m_neg_l_r ? 16'(22'd0 - sat_l_mag) : sat_l_mag[15:0];
      out_payload.right_out  <= m_neg_r_r ? 16'(22'd0 - sat_r_mag) : sat_r_mag[15:0];
      out_payload.gain_level <= m_lv_r;
      out_payload.clipped    <= clip_l || clip_r;
    end
  end

`include "volume_curve_gain_stage_core_assert.svh"

  `VCGS_ASSERT_IMPL(a_stall_hold, out_valid && out_stall, in_stall, "pipeline not held")
  `VCGS_ASSERT_IMPL(a_stall_free, !out_valid || !out_stall, !in_stall, "pipeline stalled")
  `VCGS_ASSERT_IMPL(a_clip_rail, out_valid && out_payload.clipped,
    out_payload.left_out == 16'sh7fff || out_payload.left_out == -16'sh8000 ||
    out_payload.right_out == 16'sh7fff || out_payload.right_out == -16'sh8000,
    "clip without rail")
  `VCGS_ASSERT_IMPL(a_zero_gain, out_valid && out_payload.gain_level == 16'd0,
    out_payload.left_out == 16'sd0 && out_payload.right_out == 16'sd0 &&
    !out_payload.clipped, "output at zero level")

endmodule
